// File: rtl/hsm_pkg.sv
// shared constants and types of the hash set membership table
package hsm_pkg;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam int unsigned KEY_W = 32;

	// outcome of one bucket lookup
	typedef struct packed {
		logic hit;
		logic drop;
		logic valid_we;
		logic key_we;
	} hsm_upd_t;

endpackage

// File: rtl/hash_set_membership_table.sv
// top level of the bucketed hash set membership table
//
//  channel  dir  beat contents
//  s_*      in   tdata[31:0] key (signed), tuser[1:0] req_type
//  m_*      out  tdata[0] found, tdata[1] full_drop, tdata[7:2] zero
//
// a request is loaded into the result register after acceptance through two
// registered remainder stages (reciprocal multiply, back multiply and subtract),
// a final correction feeding the bucket row read, then compare and write back.
// s_tready returns as the result is loaded, so no new request is taken before the last is through.
// after reset a clearing pass zeroes the valid ram, one bucket a cycle, while
// s_tready stays low. a result held in the output register
// does not block the next request; only its write back waits.
module hash_set_membership_table #(
	parameter int unsigned BUCKETS = 1024,
	parameter int unsigned WAYS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // key
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // found, full_drop, zero padding
);

	import hsm_pkg::*;

	localparam int unsigned AW = $clog2(BUCKETS);
	localparam logic [AW-1:0] ADDR_LAST = AW'(BUCKETS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	state_t state_q;

	logic [AW-1:0]         clr_addr_q;
	logic [AW-1:0]         bucket_q;
	logic [1:0]            op_q;
	logic [KEY_W-1:0]      key_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic                  drop_q;

	logic                  in_fire;
	logic                  out_free;
	logic                  check_fire;
	logic                  clearing;
	logic [KEY_W-1:0]      key_mag;
	logic                  rem_done;
	logic [AW-1:0]         rem;

	logic [WAYS-1:0]       valid_rd;
	logic [WAYS*KEY_W-1:0] key_rd;
	logic [WAYS-1:0]       valid_nxt;
	logic [WAYS*KEY_W-1:0] key_nxt;
	hsm_upd_t              upd;

	logic                  vram_we;
	logic [AW-1:0]         vram_waddr;
	logic [WAYS-1:0]       vram_wdata;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign clearing   = (state_q == ST_CLEAR);
	assign out_free   = !out_valid_q || m_tready;
	// write back and result load happen together, once the output slot is free
	assign check_fire = (state_q == ST_CHECK) && out_free;

	// magnitude of the key; the most negative key wraps to 2^31 unsigned
	assign key_mag = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

	hsm_rem #(
		.BUCKETS (BUCKETS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.dividend (key_mag),
		.done     (rem_done),
		.rem      (rem)
	);

	// valid ram cleared by the sweep, key ram left undefined until written
	assign vram_we    = clearing || (check_fire && upd.valid_we);
	assign vram_waddr = clearing ? clr_addr_q : bucket_q;
	assign vram_wdata = clearing ? '0 : valid_nxt;

	hsm_ram #(
		.WIDTH (WAYS),
		.DEPTH (BUCKETS)
	) u_valid_ram (
		.clk     (clk),
		.wr_en   (vram_we),
		.wr_addr (vram_waddr),
		.wr_data (vram_wdata),
		.rd_en   (rem_done),
		.rd_addr (rem),
		.rd_data (valid_rd)
	);

	hsm_ram #(
		.WIDTH (WAYS * KEY_W),
		.DEPTH (BUCKETS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (check_fire && upd.key_we),
		.wr_addr (bucket_q),
		.wr_data (key_nxt),
		.rd_en   (rem_done),
		.rd_addr (rem),
		.rd_data (key_rd)
	);

	hsm_match #(
		.WAYS (WAYS)
	) u_match (
		.op            (op_q),
		.key           (key_q),
		.valid_row     (valid_rd),
		.key_row       (key_rd),
		.upd           (upd),
		.valid_row_nxt (valid_nxt),
		.key_row_nxt   (key_nxt)
	);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// bucket row read goes out with the remainder
					if (rem_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// request payload and bucket address
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_tuser;
			key_q <= s_tdata;
		end
		if (rem_done) begin
			bucket_q <= rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (check_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (check_fire) begin
			found_q <= upd.hit;
			drop_q  <= upd.drop;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, drop_q, found_q};

`ifndef SYNTHESIS
	// a dropped insert never reports a hit
	a_drop_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("full_drop set together with found");

	// one request in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// the remainder only completes while the sequencer waits for it
	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIV))
		else $error("remainder done outside the divide state");

	// a result is never overwritten before it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");
`endif

endmodule

// File: rtl/hsm_ram.sv
// generic single write port ram with one registered read port
module hsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/hsm_rem.sv
// remainder of an unsigned key by the bucket count through a reciprocal multiply
module hsm_rem #(
	parameter int unsigned BUCKETS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hsm_pkg::KEY_W-1:0]  dividend,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] rem
);

	import hsm_pkg::*;

	localparam int unsigned RW = $clog2(BUCKETS);
	localparam logic [RW:0] BKT = (RW + 1)'(BUCKETS);
	localparam logic [KEY_W-1:0] DIV_C = KEY_W'(BUCKETS);
	// floor of 2^32 over the bucket count: the quotient estimate is low by at most one
	localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);

	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic [KEY_W-1:0]   n_s1;
	logic [KEY_W-1:0]   n_s2;
	logic [KEY_W-1:0]   q_s2;
	logic [RW:0]        r_s3;
	logic [2*KEY_W-1:0] prod;
	logic [KEY_W-1:0]   back;
	logic [KEY_W-1:0]   diff;
	logic [RW:0]        r_fix;

	// quotient estimate, then back multiply; the product never exceeds the key
	assign prod  = {32'd0, n_s1} * {32'd0, RECIP};
	assign back  = q_s2 * DIV_C;
	assign diff  = n_s2 - back;
	// partial remainder is below twice the bucket count, one subtract corrects it
	assign r_fix = (r_s3 >= BKT) ? (r_s3 - BKT) : r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_s1 <= dividend;
		end
		if (vld_s1) begin
			q_s2 <= prod[2*KEY_W-1:KEY_W];
			n_s2 <= n_s1;
		end
		if (vld_s2) begin
			r_s3 <= diff[RW:0];
		end
	end

	assign done = vld_s3;
	assign rem  = r_fix[RW-1:0];

endmodule

// File: rtl/hsm_match.sv
// way compare and row update for one bucket
module hsm_match #(
	parameter int unsigned WAYS = 4
) (
	input  logic [1:0]                     op,
	input  logic [hsm_pkg::KEY_W-1:0]      key,
	input  logic [WAYS-1:0]                valid_row,
	input  logic [WAYS*hsm_pkg::KEY_W-1:0] key_row,
	output hsm_pkg::hsm_upd_t              upd,
	output logic [WAYS-1:0]                valid_row_nxt,
	output logic [WAYS*hsm_pkg::KEY_W-1:0] key_row_nxt
);

	import hsm_pkg::*;

	logic [WAYS-1:0] hit_vec;
	logic [WAYS-1:0] hit_oh;
	logic [WAYS-1:0] free_oh;
	logic            hit;
	logic            full;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = valid_row[w] && (key_row[w*KEY_W +: KEY_W] == key);
		end
	end

	// lowest matching way, lowest free way
	assign hit_oh  = hit_vec & (~hit_vec + 1'b1);
	assign free_oh = ~valid_row & (valid_row + 1'b1);
	assign hit     = |hit_vec;
	assign full    = &valid_row;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			key_row_nxt[w*KEY_W +: KEY_W] = free_oh[w] ? key : key_row[w*KEY_W +: KEY_W];
		end
	end

	always_comb begin
		upd           = '0;
		upd.hit       = hit;
		valid_row_nxt = valid_row;
		case (op)
			OP_INSERT: begin
				if (!hit && full) begin
					upd.drop = 1'b1;
				end else if (!hit) begin
					upd.valid_we  = 1'b1;
					upd.key_we    = 1'b1;
					valid_row_nxt = valid_row | free_oh;
				end
			end
			OP_DELETE: begin
				if (hit) begin
					upd.valid_we  = 1'b1;
					valid_row_nxt = valid_row & ~hit_oh;
				end
			end
			default: begin
				// query and the unused code leave the row alone
			end
		endcase
	end

endmodule

// File: bench/tb_top.sv
// testbench of the hash set membership table: random and directed requests checked beat by beat
module tb_top;
	import hsm_pkg::*;

	localparam int unsigned BUCKETS = 1024;
	localparam int unsigned WAYS    = 4;
	localparam int unsigned SLOTS   = BUCKETS * WAYS;

	// the request code that has no operation of its own behaves as a query
	localparam logic [1:0] OP_SPARE = 2'd3;

	// clearing pass plus every item under heavy gaps and stalls, taken many times over
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 24;

	typedef struct packed {
		logic found;
		logic full_drop;
	} answer_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // key
	logic [1:0]  s_tuser  = '0;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // found, full_drop, zero padding

	// mirror of the table contents
	logic        member_valid [SLOTS];
	logic [31:0] member_key   [SLOTS];

	answer_t     pending_answers [$];
	logic [31:0] recent_keys [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left      = 0;
	int unsigned cycle_count    = 0;
	int unsigned fault_count    = 0;

	hash_set_membership_table #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding",
				cycle_count, pending_answers.size());
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off counted down here
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic note_fault(input string what);
		if (fault_count < 10)
			$display("cycle %0d: %s", cycle_count, what);
		fault_count++;
	endtask

	// applies one request to the mirror and returns the answer it must give
	function automatic answer_t apply_request(input logic [1:0] op, input logic [31:0] k);
		logic [31:0] mag;
		int unsigned base;
		int          hit_way;
		int          free_way;
		answer_t     ans;
		mag      = k[31] ? (32'd0 - k) : k;
		base     = (mag % BUCKETS) * WAYS;
		hit_way  = -1;
		free_way = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (member_valid[base + w]) begin
				if (hit_way < 0 && member_key[base + w] == k)
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		ans.found     = (hit_way >= 0);
		ans.full_drop = 1'b0;
		if (op == OP_INSERT && hit_way < 0) begin
			if (free_way >= 0) begin
				member_valid[base + free_way] = 1'b1;
				member_key[base + free_way]   = k;
			end else begin
				ans.full_drop = 1'b1;
			end
		end else if (op == OP_DELETE && hit_way >= 0) begin
			member_valid[base + hit_way] = 1'b0;
		end
		return ans;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_req(input logic [1:0] op, input logic [31:0] k);
		answer_t ans;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		ans = apply_request(op, k);
		pending_answers = {pending_answers, ans};
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				note_fault($sformatf("unexpected result beat, tdata=%02h", m_tdata));
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[0] !== want.found || m_tdata[1] !== want.full_drop
						|| m_tdata[7:2] !== 6'd0)
					note_fault($sformatf(
						"expected found=%0b full_drop=%0b pad=0, got tdata=%02h",
						want.found, want.full_drop, m_tdata));
			end
		end
	end

	task automatic test_basic_ops();
		send_req(OP_QUERY,  32'd0);
		send_req(OP_INSERT, 32'd0);
		send_req(OP_INSERT, 32'd0);   // already present
		send_req(OP_QUERY,  32'd0);
		send_req(OP_DELETE, 32'd0);
		send_req(OP_DELETE, 32'd0);   // absent by now
	endtask

	task automatic test_key_extremes();
		send_req(OP_INSERT, 32'h8000_0000);  // magnitude 2^31, bucket 0
		send_req(OP_QUERY,  32'h8000_0000);
		send_req(OP_INSERT, 32'h7FFF_FFFF);  // top bucket
		send_req(OP_INSERT, 32'd1);
		send_req(OP_QUERY,  32'hFFFF_FFFF);  // minus one shares the bucket, not the key
	endtask

	task automatic test_bucket_overflow();
		send_req(OP_INSERT, 32'd5);
		send_req(OP_INSERT, 32'd5 + BUCKETS);
		send_req(OP_INSERT, 32'd0 - (32'd5 + 2 * BUCKETS));
		send_req(OP_INSERT, 32'd5 + 3 * BUCKETS);
		send_req(OP_INSERT, 32'd5 + 4 * BUCKETS);  // bucket full, dropped
		send_req(OP_DELETE, 32'd5 + BUCKETS);
		send_req(OP_INSERT, 32'd5 + 4 * BUCKETS);  // lands in the freed way
		send_req(OP_QUERY,  32'd5 + 4 * BUCKETS);
	endtask

	task automatic test_spare_opcode();
		send_req(OP_SPARE, 32'd5);
		send_req(OP_SPARE, 32'd6);
	endtask

	// mostly keys crowded into a few buckets so that ways fill, hit and free again
	task automatic test_random_mix(input int unsigned count);
		int unsigned hot [8];
		int unsigned pick;
		logic [31:0] mag;
		logic [31:0] k;
		logic [1:0]  op;
		hot = '{0, 1, 5, 37, 512, 700, BUCKETS - 2, BUCKETS - 1};
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				mag = hot[$urandom_range(0, 7)] + BUCKETS * $urandom_range(0, 6);
				k   = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end else if (pick < 80 && recent_keys.size() != 0) begin
				k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			end else begin
				k = $urandom;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = OP_INSERT;
			else if (pick < 65)
				op = OP_QUERY;
			else if (pick < 95)
				op = OP_DELETE;
			else
				op = OP_SPARE;
			if (op == OP_INSERT) begin
				recent_keys = {recent_keys, k};
				if (recent_keys.size() > 16)
					void'(recent_keys.pop_front());
			end
			send_req(op, k);
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_output_holdoff();
		send_idle_pct = 0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		test_random_mix(60);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			member_valid[i] = 1'b0;
			member_key[i]   = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_key_extremes();
		test_bucket_overflow();
		test_spare_opcode();

		send_idle_pct = 0;  recv_stall_pct = 0;
		test_random_mix(245);
		send_idle_pct = 81; recv_stall_pct = 0;
		test_random_mix(245);
		send_idle_pct = 0;  recv_stall_pct = 81;
		test_random_mix(245);
		send_idle_pct = 38; recv_stall_pct = 38;
		test_random_mix(245);
		test_output_holdoff();

		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
